// ----- rtl/multi_stop_colour_gradient_assert.svh -----
// assertion macros used by the gradient checker
`ifndef MULTI_STOP_COLOUR_GRADIENT_ASSERT_SVH
`define MULTI_STOP_COLOUR_GRADIENT_ASSERT_SVH

// condition implies consequence in the same cycle, checked out of reset
`define MSCG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle, reset not masked
`define MSCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mscg_pkg.sv -----
// package: payload types, stop record, sequencer states and constants
package mscg_pkg;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_MID    = 2'd1,
        MODE_TARGET = 2'd2,
        MODE_EVAL   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  particle;
        logic [16:0] stop_time;
        logic [16:0] life_progress;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [15:0] alpha_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  particle_out;
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [15:0] alpha_out;
    } t_out_item;

    // channel 0 red, 1 green, 2 blue, 3 alpha
    typedef struct packed {
        logic [16:0]      tstamp;
        logic [3:0][15:0] colour;
    } t_stop;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WR,
        S_FILL_WAIT,
        S_FILL_USE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_EV_RD,
        S_EV_GET,
        S_EV_DIV,
        S_EV_MUL,
        S_EV_ACC,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/mscg_store.sv -----
// stop memory and per-particle fill count memory, registered reads
module mscg_store #(
    parameter int AW     = 12,
    parameter int DEPTH  = 2560,
    parameter int FW     = 8,
    parameter int FDEPTH = 256,
    parameter int CW     = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  mscg_pkg::t_stop   i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output mscg_pkg::t_stop   o_rdata,
    input  logic              i_fwe,
    input  logic [FW-1:0]     i_faddr,
    input  logic [CW-1:0]     i_fwdata,
    output logic [CW-1:0]     o_frdata
);
    import mscg_pkg::*;

    t_stop      r_stops [DEPTH];
    logic [CW-1:0] r_fill [FDEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_stops[i_waddr] <= i_wdata;
        end
        o_rdata <= r_stops[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_fwe) begin
            r_fill[i_faddr] <= i_fwdata;
        end
        o_frdata <= r_fill[i_faddr];
    end

endmodule

// ----- rtl/mscg_frac_div.sv -----
// segment fraction unit: one restoring division step per cycle
module mscg_frac_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_p,
    input  logic [16:0] i_t0,
    input  logic [16:0] i_t1,
    output logic        o_done,
    output logic [16:0] o_frac
);
    import mscg_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [16:0] r_rem;
    logic [16:0] r_span;
    logic [15:0] r_q;
    logic [3:0]  r_cnt;
    logic [16:0] r_frac;

    logic [16:0] diff;
    logic [16:0] span;
    logic [17:0] shifted;
    logic        fits;
    logic [16:0] n_rem;
    logic [15:0] n_q;

    assign diff    = i_p - i_t0;
    assign span    = i_t1 - i_t0;
    assign shifted = {r_rem, 1'b0};
    assign fits    = shifted >= {1'b0, r_span};
    assign n_rem   = fits ? 17'(shifted - {1'b0, r_span}) : shifted[16:0];
    assign n_q     = {r_q[14:0], fits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_p < i_t0) begin
                    r_frac <= '0;
                    r_done <= 1'b1;
                end else if (i_t1 <= i_t0 || diff >= span) begin
                    r_frac <= ONE_Q16;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= diff;
                    r_span <= span;
                    r_q    <= '0;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_frac <= {1'b0, n_q};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_frac = r_frac;

endmodule

// ----- rtl/multi_stop_colour_gradient.sv -----
// evaluate: the start stop is read, then per segment (one per stop in use plus one to the
// target) the next stop is read, the fraction divided (no division when not needed) and
// each channel multiplied and accumulated; start/target loads write one stop, an
// intermediate shifts later stops up one slot each, dropped when full; one item at a time
// synchronous active-low reset clears control and the stop-count register; stop memories
// are not cleared; the user must write a particle's stops before evaluating it, unenforced
module multi_stop_colour_gradient #(
    parameter int PARTICLES        = 256,
    parameter int MAX_INTERMEDIATE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mscg_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mscg_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_wdata
);
    import mscg_pkg::*;

    localparam int SLOTS  = MAX_INTERMEDIATE + 2;
    localparam int DEPTH  = PARTICLES * SLOTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int SW     = $clog2(SLOTS);
    localparam int CW     = $clog2(MAX_INTERMEDIATE + 2);
    localparam int FW     = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam logic [SW-1:0] TARGET = SW'(SLOTS - 1);

    t_state        r_state, n_state;
    logic [3:0]    r_num;
    t_mode         r_mode, n_mode;
    logic [7:0]    r_part, n_part;
    logic [AW-1:0] r_base, n_base;
    logic [16:0]   r_t, n_t;
    logic [16:0]   r_p, n_p;
    logic [3:0][15:0] r_colour, n_colour;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_seg, n_seg;
    logic [SW-1:0] r_rdslot, n_rdslot;
    logic          r_first, n_first;
    t_stop         r_prev, n_prev;
    t_stop         r_cur, n_cur;
    logic [16:0]   r_f, n_f;
    logic [1:0]    r_ch, n_ch;
    logic [16:0]   r_prod, n_prod;
    logic          r_neg, n_neg;
    logic signed [23:0] r_acc [4];
    logic signed [23:0] n_acc [4];
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_stop         mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_stop         mem_rdata;
    logic          fill_we;
    logic [CW-1:0] fill_wdata;
    logic [CW-1:0] fill_rdata;
    logic          div_start;
    logic          div_done;
    logic [16:0]   div_frac;

    logic [CW-1:0] cap;
    logic          accept;
    logic [16:0]   in_time;
    logic [16:0]   in_prog;
    logic [15:0]   c0, c1, mag;
    logic [15:0]   sat [4];

    assign cap = (32'(r_num) < MAX_INTERMEDIATE) ? CW'(r_num) : CW'(MAX_INTERMEDIATE);
    assign o_in_stall = (r_state != S_IDLE);
    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign in_time = (i_in_data.stop_time > ONE_Q16) ? ONE_Q16 : i_in_data.stop_time;
    assign in_prog = (i_in_data.life_progress > ONE_Q16) ? ONE_Q16
                                                          : i_in_data.life_progress;
    assign c0  = r_prev.colour[r_ch];
    assign c1  = r_cur.colour[r_ch];
    assign mag = (c1 >= c0) ? 16'(c1 - c0) : 16'(c0 - c1);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (r_acc[c] < 0) begin
                sat[c] = '0;
            end else if (r_acc[c] > 24'sd65535) begin
                sat[c] = 16'hFFFF;
            end else begin
                sat[c] = r_acc[c][15:0];
            end
        end
    end

    mscg_store #(
        .AW(AW), .DEPTH(DEPTH), .FW(FW), .FDEPTH(PARTICLES), .CW(CW)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr  (mem_raddr),
        .o_rdata  (mem_rdata),
        .i_fwe    (fill_we),
        .i_faddr  (FW'(r_part)),
        .i_fwdata (fill_wdata),
        .o_frdata (fill_rdata)
    );

    mscg_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_p     (r_p),
        .i_t0    (r_prev.tstamp),
        .i_t1    (mem_rdata.tstamp),
        .o_done  (div_done),
        .o_frac  (div_frac)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_num       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_num <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_part   <= n_part;
        r_base   <= n_base;
        r_t      <= n_t;
        r_p      <= n_p;
        r_colour <= n_colour;
        r_k      <= n_k;
        r_n      <= n_n;
        r_pos    <= n_pos;
        r_seg    <= n_seg;
        r_rdslot <= n_rdslot;
        r_first  <= n_first;
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_f      <= n_f;
        r_ch     <= n_ch;
        r_prod   <= n_prod;
        r_neg    <= n_neg;
        r_acc    <= n_acc;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_part      = r_part;
        n_base      = r_base;
        n_t         = r_t;
        n_p         = r_p;
        n_colour    = r_colour;
        n_k         = r_k;
        n_n         = r_n;
        n_pos       = r_pos;
        n_seg       = r_seg;
        n_rdslot    = r_rdslot;
        n_first     = r_first;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_f         = r_f;
        n_ch        = r_ch;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = r_base + AW'(r_pos) + AW'(1);
        mem_wdata   = {r_t, r_colour};
        mem_raddr   = r_base + AW'(r_pos);
        fill_we     = 1'b0;
        fill_wdata  = '0;
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode   = i_in_data.mode;
                    n_part   = i_in_data.particle;
                    n_base   = AW'(32'(i_in_data.particle) * SLOTS);
                    n_p      = in_prog;
                    n_colour = {i_in_data.alpha_in, i_in_data.blue_in,
                                i_in_data.green_in, i_in_data.red_in};
                    if (32'(i_in_data.particle) < PARTICLES) begin
                        unique case (i_in_data.mode)
                            MODE_START: begin
                                n_t     = '0;
                                n_state = S_WR;
                            end
                            MODE_TARGET: begin
                                n_t     = ONE_Q16;
                                n_state = S_WR;
                            end
                            default: begin
                                n_t     = in_time;
                                n_state = S_FILL_WAIT;
                            end
                        endcase
                    end
                end
            end
            S_WR: begin
                mem_we = 1'b1;
                if (r_mode == MODE_START) begin
                    mem_waddr = r_base;
                    fill_we   = 1'b1;
                end else begin
                    mem_waddr = r_base + AW'(TARGET);
                end
                n_state = S_IDLE;
            end
            S_FILL_WAIT: begin
                n_state = S_FILL_USE;
            end
            S_FILL_USE: begin
                if (r_mode == MODE_MID) begin
                    if (fill_rdata >= cap) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = fill_rdata;
                        n_pos   = fill_rdata;
                        n_state = S_INS_RD;
                    end
                end else begin
                    n_n      = (fill_rdata > cap) ? cap : fill_rdata;
                    n_first  = 1'b1;
                    n_rdslot = '0;
                    n_state  = S_EV_RD;
                end
            end
            S_INS_RD: begin
                n_state = (r_pos == '0) ? S_INS_PUT : S_INS_CMP;
            end
            S_INS_CMP: begin
                // shift a later stop up one slot to open a gap
                if (mem_rdata.tstamp > r_t) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    n_pos     = r_pos - CW'(1);
                    n_state   = S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                mem_we     = 1'b1;
                fill_we    = 1'b1;
                fill_wdata = r_k + CW'(1);
                n_state    = S_IDLE;
            end
            S_EV_RD: begin
                mem_raddr = r_base + AW'(r_rdslot);
                n_state   = S_EV_GET;
            end
            S_EV_GET: begin
                if (r_first) begin
                    n_prev  = mem_rdata;
                    n_first = 1'b0;
                    n_seg   = '0;
                    for (int c = 0; c < 4; c++) begin
                        n_acc[c] = 24'(mem_rdata.colour[c]);
                    end
                    n_rdslot = (r_n != '0) ? SW'(1) : TARGET;
                    n_state  = S_EV_RD;
                end else begin
                    n_cur     = mem_rdata;
                    div_start = 1'b1;
                    n_state   = S_EV_DIV;
                end
            end
            S_EV_DIV: begin
                if (div_done) begin
                    n_f     = div_frac;
                    n_ch    = '0;
                    n_state = S_EV_MUL;
                end
            end
            S_EV_MUL: begin
                n_prod  = 17'((33'(mag) * 33'(r_f)) >> 16);
                n_neg   = c1 < c0;
                n_state = S_EV_ACC;
            end
            S_EV_ACC: begin
                n_acc[r_ch] = r_neg ? r_acc[r_ch] - 24'(r_prod) : r_acc[r_ch] + 24'(r_prod);
                if (r_ch == 2'd3) begin
                    n_prev = r_cur;
                    if (r_seg == r_n) begin
                        n_state = S_EMIT;
                    end else begin
                        n_seg    = r_seg + CW'(1);
                        n_rdslot = ((r_seg + CW'(1)) < r_n) ? SW'(r_seg) + SW'(2) : TARGET;
                        n_state  = S_EV_RD;
                    end
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = S_EV_MUL;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.particle_out = r_part;
                    n_out.red_out      = sat[0];
                    n_out.green_out    = sat[1];
                    n_out.blue_out     = sat[2];
                    n_out.alpha_out    = sat[3];
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/mscg_checker.sv -----
// port-level checker for the gradient block, bound to the top level
`include "multi_stop_colour_gradient_assert.svh"

module mscg_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input mscg_pkg::t_out_item o_out_data
);
    import mscg_pkg::*;

    `MSCG_ASSERT_NEXT(a_out_hold, i_rst_n && o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `MSCG_ASSERT_NEXT(a_out_stable, i_rst_n && o_out_valid && i_out_stall, $stable(o_out_data), "stalled result changed")
    `MSCG_ASSERT_NEXT(a_busy_after_take, i_rst_n && i_in_valid && !o_in_stall, o_in_stall, "input not held off after transfer")
    `MSCG_ASSERT_NEXT(a_reset_clears, !i_rst_n, !o_out_valid && !o_in_stall, "reset left block busy or valid")

endmodule

bind multi_stop_colour_gradient mscg_checker u_mscg_checker (.*);
